// ----- sv/c2s_pkg.sv -----
`default_nettype none

package c2s_pkg;

    localparam int FB  = 14;
    localparam int LVW = 9;
    localparam int CW  = 24;
    localparam int NMW = 16;
    localparam int FACEW = 3;
    localparam int CFG_IDXW = 2;
    localparam int DEF_MAX_LEVELS = 256;
    localparam int FACE_LAST = 5;
    localparam logic [LVW-1:0] LEVEL_RESET = LVW'(8);

    typedef enum logic [CFG_IDXW-1:0] {
        REG_LEVEL_COUNT = 2'd0,
        REG_CENTER_X    = 2'd1,
        REG_CENTER_Y    = 2'd2,
        REG_CENTER_Z    = 2'd3
    } cfg_reg_t;

    typedef logic signed [1:0] unit_t;

    // Per face: origin xyz, half of right xyz, half of up xyz.
    localparam unit_t FACE_TBL [6][9] = '{
        '{-2'sd1, -2'sd1, -2'sd1,  2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd1,  2'sd0},
        '{ 2'sd1, -2'sd1, -2'sd1,  2'sd0,  2'sd0,  2'sd1,  2'sd0,  2'sd1,  2'sd0},
        '{ 2'sd1, -2'sd1,  2'sd1, -2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd1,  2'sd0},
        '{-2'sd1, -2'sd1,  2'sd1,  2'sd0,  2'sd0, -2'sd1,  2'sd0,  2'sd1,  2'sd0},
        '{-2'sd1,  2'sd1, -2'sd1,  2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0,  2'sd1},
        '{-2'sd1, -2'sd1,  2'sd1,  2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0, -2'sd1}
    };

endpackage

`default_nettype wire

// ----- sv/cube_to_sphere_vertex_unit.sv -----
// Throughput: one word per cycle while m_tready is high; a 15-stage divider
// and a 15-stage square root run one bit per stage, and stalled stages only
// hold while empty stages still fill.
// Reset: rst_n is asynchronous and active low; it empties the pipeline and
// sets level_count to 8 and the center to zero.
`default_nettype none

module cube_to_sphere_vertex_unit
    import c2s_pkg::*;
#(
    parameter int MAX_LEVELS = DEF_MAX_LEVELS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CFG_IDXW-1:0] cfg_index,
    input  wire logic [CW-1:0]       cfg_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // face [2:0], col [11:3], row [20:12], zero fill [23:21]
    input  wire logic [23:0]         s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // vertex_x, vertex_y, vertex_z (24 bits each), normal_x, normal_y, normal_z (16 bits each)
    output logic [119:0]             m_tdata
);

    localparam int QW  = FB + 1;
    localparam int DW  = LVW + FB + 2;
    localparam int VW  = LVW + 1;
    localparam int SQW = FB + 1;
    localparam int UW  = 32;
    localparam int AW  = 2 * FB + 2;
    localparam int RS  = FB + 1;
    localparam int RW  = FB + 2;
    localparam int PW  = QW + RW;
    localparam int MW  = PW - FB;
    localparam int NXW = 13;

    localparam int S_SQ  = QW + 1;
    localparam int S_U   = QW + 2;
    localparam int S_M6  = QW + 3;
    localparam int S_R0  = QW + 4;
    localparam int S_RT  = S_R0 + RS;
    localparam int S_NM  = S_RT + 1;
    localparam int S_OUT = S_NM + 1;
    localparam int NS    = S_OUT + 1;

    localparam logic [UW-1:0] U_BASE = UW'(6) << (2 * FB);
    localparam logic [31:0]   RECIP3 = 32'hAAAAAAAB;
    localparam logic [PW-1:0] HALF_P = PW'(1) << (FB - 1);
    localparam logic [2*QW-1:0] HALF_S = (2*QW)'(1) << (FB - 1);
    localparam logic signed [CW:0] VMAX = (CW+1)'(8388607);
    localparam logic signed [CW:0] VMIN = -(CW+1)'(8388608);

    logic [LVW-1:0]       level_reg;
    logic signed [CW-1:0] center_reg [3];

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    logic [DW-1:0]  rem_reg  [QW+1][3];
    logic [QW-1:0]  q_reg    [QW+1][3];
    logic [2:0]     sgn_reg  [NS-1];
    logic [VW-1:0]  dv_reg   [QW+1];
    logic [QW-1:0]  qf_reg   [S_OUT-S_SQ][3];
    logic [SQW-1:0] sq_reg   [3];
    logic [UW-1:0]  u_reg    [3];
    logic [63:0]    t_reg    [3];
    logic [AW-1:0]  ra_reg   [RS][3];
    logic [AW-1:0]  rr_reg   [RS][3];
    logic [RW-1:0]  root_reg [3];
    logic [PW-1:0]  prod_reg [3];
    logic [119:0]   out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= LEVEL_RESET;
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LEVEL_COUNT: level_reg     <= cfg_data[LVW-1:0];
                REG_CENTER_X:    center_reg[0] <= cfg_data;
                REG_CENTER_Y:    center_reg[1] <= cfg_data;
                REG_CENTER_Z:    center_reg[2] <= cfg_data;
                default:         level_reg     <= level_reg;
            endcase
        end
    end

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NS-1];
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= (i == 0) ? s_tvalid : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // Input stage: clamp, select the face vectors and set up the divider.
    logic [LVW-1:0]        lv_c;
    logic [LVW-1:0]        col_c;
    logic [LVW-1:0]        row_c;
    logic [FACEW-1:0]      face_c;
    logic signed [NXW-1:0] num_c [3];
    logic [NXW-1:0]        mag_c [3];

    always_comb
    begin
        lv_c = level_reg;
        if (lv_c == '0)
        begin
            lv_c = LVW'(1);
        end
        if (32'(lv_c) > MAX_LEVELS)
        begin
            lv_c = LVW'(MAX_LEVELS);
        end
        col_c  = (s_tdata[11:3] > lv_c) ? lv_c : s_tdata[11:3];
        row_c  = (s_tdata[20:12] > lv_c) ? lv_c : s_tdata[20:12];
        face_c = (s_tdata[2:0] > FACEW'(FACE_LAST)) ? FACEW'(FACE_LAST) : s_tdata[2:0];
        for (int k = 0; k < 3; k++)
        begin
            num_c[k] = NXW'(FACE_TBL[face_c][k]) * $signed({4'b0, lv_c})
                     + NXW'(2) * (NXW'(FACE_TBL[face_c][3+k]) * $signed({4'b0, col_c})
                     + NXW'(FACE_TBL[face_c][6+k]) * $signed({4'b0, row_c}));
            mag_c[k] = num_c[k][NXW-1] ? NXW'(-num_c[k]) : NXW'(num_c[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dv_reg[0] <= {lv_c, 1'b0};
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[0][k] <= (DW'(mag_c[k][LVW-1:0]) << (FB + 1)) + DW'(lv_c);
                q_reg[0][k]   <= '0;
                sgn_reg[0][k] <= num_c[k][NXW-1];
            end
        end
    end

    // Divider: one quotient bit per stage.
    for (genvar j = 1; j <= QW; j++)
    begin : g_div
        logic [DW-1:0] trial;
        assign trial = DW'(dv_reg[j-1]) << (QW - j);
        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                dv_reg[j] <= dv_reg[j-1];
                for (int k = 0; k < 3; k++)
                begin
                    sgn_reg[j][k] <= sgn_reg[j-1][k];
                    if (rem_reg[j-1][k] >= trial)
                    begin
                        rem_reg[j][k] <= rem_reg[j-1][k] - trial;
                        q_reg[j][k]   <= {q_reg[j-1][k][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[j][k] <= rem_reg[j-1][k];
                        q_reg[j][k]   <= {q_reg[j-1][k][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Square of each coordinate, then the square-root argument times six, then that divided by six.
    always_ff @(posedge clk)
    begin
        if (en[S_SQ])
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k]     <= SQW'(((2*QW)'(q_reg[QW][k]) * (2*QW)'(q_reg[QW][k])
                                 + HALF_S) >> FB);
                qf_reg[0][k]  <= q_reg[QW][k];
                sgn_reg[S_SQ][k] <= sgn_reg[QW][k];
            end
        end
        if (en[S_U])
        begin
            for (int k = 0; k < 3; k++)
            begin
                u_reg[k] <= U_BASE + UW'(3)
                          + (UW'(UW'(sq_reg[(k+1)%3]) * UW'(sq_reg[(k+2)%3])) << 1)
                          - ((UW'(3) * (UW'(sq_reg[(k+1)%3]) + UW'(sq_reg[(k+2)%3]))) << FB);
                qf_reg[1][k]    <= qf_reg[0][k];
                sgn_reg[S_U][k] <= sgn_reg[S_SQ][k];
            end
        end
        if (en[S_M6])
        begin
            for (int k = 0; k < 3; k++)
            begin
                t_reg[k]         <= 64'({1'b0, u_reg[k][UW-1:1]}) * 64'(RECIP3);
                qf_reg[2][k]     <= qf_reg[1][k];
                sgn_reg[S_M6][k] <= sgn_reg[S_U][k];
            end
        end
    end

    // Square root: one result bit per stage.
    for (genvar s = 0; s < RS; s++)
    begin : g_sqrt
        localparam logic [AW:0] BIT = (AW+1)'(1) << (AW - 2 - 2 * s);
        logic [AW-1:0] a_in  [3];
        logic [AW-1:0] r_in  [3];
        logic [AW:0]   cmp   [3];
        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (s == 0)
                begin
                    a_in[k] = t_reg[k][33+AW-1:33];
                    r_in[k] = '0;
                end
                else
                begin
                    a_in[k] = ra_reg[(s == 0) ? 0 : s-1][k];
                    r_in[k] = rr_reg[(s == 0) ? 0 : s-1][k];
                end
                cmp[k] = (AW+1)'(r_in[k]) + BIT;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en[S_R0+s])
            begin
                for (int k = 0; k < 3; k++)
                begin
                    qf_reg[3+s][k]     <= qf_reg[2+s][k];
                    sgn_reg[S_R0+s][k] <= sgn_reg[S_R0+s-1][k];
                    if ((AW+1)'(a_in[k]) >= cmp[k])
                    begin
                        ra_reg[s][k] <= AW'((AW+1)'(a_in[k]) - cmp[k]);
                        rr_reg[s][k] <= AW'((AW+1)'(r_in[k] >> 1) + BIT);
                    end
                    else
                    begin
                        ra_reg[s][k] <= a_in[k];
                        rr_reg[s][k] <= r_in[k] >> 1;
                    end
                end
            end
        end
    end

    logic signed [MW:0]   n_c   [3];
    logic signed [CW:0]   sum_c [3];
    logic signed [CW-1:0] vtx_c [3];
    logic [NMW-1:0]       nrm_c [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            n_c[k]   = sgn_reg[S_NM][k] ? -$signed({1'b0, MW'((prod_reg[k] + HALF_P) >> FB)})
                                        :  $signed({1'b0, MW'((prod_reg[k] + HALF_P) >> FB)});
            sum_c[k] = (CW+1)'(n_c[k]) + (CW+1)'(center_reg[k]);
            if (sum_c[k] > VMAX)
            begin
                vtx_c[k] = VMAX[CW-1:0];
            end
            else if (sum_c[k] < VMIN)
            begin
                vtx_c[k] = VMIN[CW-1:0];
            end
            else
            begin
                vtx_c[k] = sum_c[k][CW-1:0];
            end
            nrm_c[k] = NMW'(-n_c[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_RT])
        begin
            for (int k = 0; k < 3; k++)
            begin
                root_reg[k] <= RW'(rr_reg[RS-1][k])
                             + RW'(ra_reg[RS-1][k] > rr_reg[RS-1][k]);
                qf_reg[RS+3][k]    <= qf_reg[RS+2][k];
                sgn_reg[S_RT][k]   <= sgn_reg[S_RT-1][k];
            end
        end
        if (en[S_NM])
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k]      <= PW'(qf_reg[RS+3][k]) * PW'(root_reg[k]);
                sgn_reg[S_NM][k] <= sgn_reg[S_RT][k];
            end
        end
        if (en[S_OUT])
        begin
            out_reg <= {nrm_c[2], nrm_c[1], nrm_c[0], vtx_c[2], vtx_c[1], vtx_c[0]};
        end
    end

endmodule

`default_nettype wire

// ----- sv/c2s_checker.sv -----
`default_nettype none

module c2s_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [119:0] m_tdata
);

    property p_hold;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata);
    endproperty

    property p_norm_x;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[87:72]) <= 16'sd16384
                      && $signed(m_tdata[87:72]) >= -16'sd16384);
    endproperty

    property p_norm_y;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[103:88]) <= 16'sd16384
                      && $signed(m_tdata[103:88]) >= -16'sd16384);
    endproperty

    property p_norm_z;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[119:104]) <= 16'sd16384
                      && $signed(m_tdata[119:104]) >= -16'sd16384);
    endproperty

    a_hold:   assert property (p_hold)   else $error("output word changed while stalled");
    a_norm_x: assert property (p_norm_x) else $error("normal_x out of range");
    a_norm_y: assert property (p_norm_y) else $error("normal_y out of range");
    a_norm_z: assert property (p_norm_z) else $error("normal_z out of range");

endmodule

bind cube_to_sphere_vertex_unit c2s_checker u_c2s_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
